// ===== sv/lmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared constants and state encoding for the latency mean and standard
// deviation core.
// ----------------------------------------------------------------------------
package lmsd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_SAMPLES = 64;
    localparam int US_PER_MS   = 1000;

    localparam int CNT_W  = 7;
    localparam int SUM_W  = 30;
    localparam int SQ_W   = 54;
    localparam int OUT_W  = 31;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int B_W    = 2 * SUM_W;
    localparam int VAR_W  = SQ_W + CNT_W;
    localparam int NN_W   = 2 * CNT_W - 2;
    localparam int DIV_W  = VAR_W + 32;
    localparam int X_W    = 62;
    localparam int ROOT_W = X_W + 1;

    localparam int MEAN_STEPS = SUM_W + 16;
    localparam int SD_STEPS   = DIV_W;
    localparam int ROOT_STEPS = X_W / 2 + 1;

    localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};
    localparam logic [MUL_W-1:0] US2      = MUL_W'(US_PER_MS * US_PER_MS);
    localparam logic [MUL_W-1:0] US1      = MUL_W'(US_PER_MS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_ACC   = 12'b0000_0000_0010,
        S_M_SS  = 12'b0000_0000_0100,
        S_M_ALO = 12'b0000_0000_1000,
        S_M_AHI = 12'b0000_0001_0000,
        S_M_NN1 = 12'b0000_0010_0000,
        S_M_DSD = 12'b0000_0100_0000,
        S_M_DM  = 12'b0000_1000_0000,
        S_DIV_M = 12'b0001_0000_0000,
        S_DIV_S = 12'b0010_0000_0000,
        S_SQRT  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== sv/latency_mean_and_std_deviation_core.sv =====
// A batch-closing sample passes an accumulate step, the multiply steps, the mean divide,
//   the deviation divide, the root and an output step; the root is skipped when the
//   deviation saturates, and both deviation steps when it is zero by rule.
// A new sample is taken only after the last one is accumulated; the closing sample holds
//   the input until its result is in the output register.
// reset: accumulators and sample counter clear, sample_count returns to 10
// ----------------------------------------------------------------------------
// latency_mean_and_std_deviation_core
// Batch mean and sample standard deviation of latency samples, ms in Q15.16,
// computed by a small sequencer over one shared multiplier, divider and root.
// ----------------------------------------------------------------------------
module latency_mean_and_std_deviation_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lmsd_pkg::SAMPLE_BITS-1:0]  latency_us,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lmsd_pkg::OUT_W-1:0]        mean_ms,
    output logic [lmsd_pkg::OUT_W-1:0]        std_dev_ms,
    input  logic                              cfg_wr_en,
    input  logic [lmsd_pkg::CNT_W-1:0]        cfg_wr_data
);

    import lmsd_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        sample_count_reg;
    logic [CNT_W-1:0]        target;
    logic                    out_valid_reg;
    logic                    can_load;

    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [CNT_W-1:0]        seen_reg;
    logic [CNT_W-1:0]        seen_next;

    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [PROD_W-1:0]       mul_p;

    logic [B_W-1:0]          b_reg;
    logic [VAR_W-1:0]        a_reg;
    logic [NN_W-1:0]         nn_reg;
    logic [MUL_W-1:0]        dsd_reg;
    logic [VAR_W-1:0]        var_reg;
    logic                    var_pos_reg;

    logic [DIV_W-1:0]        num_reg;
    logic [MUL_W-1:0]        den_reg;
    logic [MUL_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        quo_reg;
    logic [MUL_W:0]          div_shift;
    logic [MUL_W:0]          div_diff;
    logic                    div_ge;
    logic [MUL_W-1:0]        rem_next;
    logic [DIV_W-1:0]        quo_next;

    logic [X_W-1:0]          x_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [ROOT_W-1:0]       bit_reg;
    logic [ROOT_W-1:0]       trial;
    logic                    root_ge;
    logic [X_W-1:0]          x_next;
    logic [ROOT_W-1:0]       root_next;

    logic [CNT_W-1:0]        cnt_reg;
    logic                    cnt_last;
    logic                    sd_start;

    logic [OUT_W-1:0]        mean_reg;
    logic [OUT_W-1:0]        sd_reg;
    logic [OUT_W-1:0]        mean_out_reg;
    logic [OUT_W-1:0]        sd_out_reg;

    // effective batch size
    always_comb
    begin
        priority if (sample_count_reg == '0)
        begin
            target = CNT_ONE;
        end
        else if (sample_count_reg > CNT_MAX)
        begin
            target = CNT_MAX;
        end
        else
        begin
            target = sample_count_reg;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign mean_ms    = mean_out_reg;
    assign std_dev_ms = sd_out_reg;
    assign can_load   = !out_valid_reg || !out_stall;
    assign seen_next  = seen_reg + CNT_ONE;
    assign cnt_last   = (cnt_reg == CNT_ONE);
    assign sd_start   = (seen_reg >= CNT_TWO) && var_pos_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ACC:
            begin
                mul_a = MUL_W'(sample_reg);
                mul_b = MUL_W'(sample_reg);
            end
            S_M_SS:
            begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            S_M_ALO:
            begin
                mul_a = MUL_W'(seen_reg);
                mul_b = sq_reg[MUL_W-1:0];
            end
            S_M_AHI:
            begin
                mul_a = MUL_W'(seen_reg);
                mul_b = MUL_W'(sq_reg[SQ_W-1:MUL_W]);
            end
            S_M_NN1:
            begin
                mul_a = MUL_W'(seen_reg);
                mul_b = MUL_W'(seen_reg - CNT_ONE);
            end
            S_M_DSD:
            begin
                mul_a = MUL_W'(nn_reg);
                mul_b = US2;
            end
            S_M_DM:
            begin
                mul_a = MUL_W'(seen_reg);
                mul_b = US1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // restoring divider step
    assign div_shift = {rem_reg, num_reg[DIV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign div_diff  = div_shift - {1'b0, den_reg};
    assign rem_next  = div_ge ? div_diff[MUL_W-1:0] : div_shift[MUL_W-1:0];
    assign quo_next  = {quo_reg[DIV_W-2:0], div_ge};

    // digit-by-digit square root step
    assign trial     = root_reg + bit_reg;
    assign root_ge   = ({1'b0, x_reg} >= trial);
    assign x_next    = root_ge ? (x_reg - trial[X_W-1:0]) : x_reg;
    assign root_next = root_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = (seen_next >= target) ? S_M_SS : S_IDLE;
            end
            S_M_SS:
            begin
                state_next = S_M_ALO;
            end
            S_M_ALO:
            begin
                state_next = S_M_AHI;
            end
            S_M_AHI:
            begin
                state_next = S_M_NN1;
            end
            S_M_NN1:
            begin
                state_next = S_M_DSD;
            end
            S_M_DSD:
            begin
                state_next = S_M_DM;
            end
            S_M_DM:
            begin
                state_next = S_DIV_M;
            end
            S_DIV_M:
            begin
                if (cnt_last)
                begin
                    state_next = sd_start ? S_DIV_S : S_DONE;
                end
            end
            S_DIV_S:
            begin
                if (cnt_last)
                begin
                    state_next = (|quo_next[DIV_W-1:X_W]) ? S_DONE : S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (cnt_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_count_reg <= CNT_W'(10);
            out_valid_reg    <= 1'b0;
            sum_reg          <= '0;
            sq_reg           <= '0;
            seen_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                sample_count_reg <= cfg_wr_data;
            end
            if ((state_reg == S_DONE) && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_ACC)
            begin
                sum_reg  <= sum_reg + SUM_W'(sample_reg);
                sq_reg   <= sq_reg + mul_p[SQ_W-1:0];
                seen_reg <= seen_next;
            end
            else if ((state_reg == S_DONE) && can_load)
            begin
                sum_reg  <= '0;
                sq_reg   <= '0;
                seen_reg <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_reg <= latency_us;
                end
            end
            S_M_SS:
            begin
                b_reg <= mul_p[B_W-1:0];
            end
            S_M_ALO:
            begin
                a_reg <= VAR_W'(mul_p);
            end
            S_M_AHI:
            begin
                a_reg <= a_reg + {mul_p[VAR_W-MUL_W-1:0], {MUL_W{1'b0}}};
            end
            S_M_NN1:
            begin
                nn_reg <= mul_p[NN_W-1:0];
            end
            S_M_DSD:
            begin
                dsd_reg <= mul_p[MUL_W-1:0];
                if (a_reg >= {1'b0, b_reg})
                begin
                    var_reg     <= a_reg - {1'b0, b_reg};
                    var_pos_reg <= 1'b1;
                end
                else
                begin
                    var_reg     <= '0;
                    var_pos_reg <= 1'b0;
                end
            end
            S_M_DM:
            begin
                den_reg <= mul_p[MUL_W-1:0];
                num_reg <= {sum_reg, {(DIV_W-SUM_W){1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CNT_W'(MEAN_STEPS);
            end
            S_DIV_M:
            begin
                num_reg <= {num_reg[DIV_W-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_ONE;
                if (cnt_last)
                begin
                    mean_reg <= (quo_next > DIV_W'(OUT_MAX)) ? OUT_MAX : quo_next[OUT_W-1:0];
                    if (sd_start)
                    begin
                        num_reg <= {var_reg, {(DIV_W-VAR_W){1'b0}}};
                        den_reg <= dsd_reg;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= CNT_W'(SD_STEPS);
                    end
                    else
                    begin
                        sd_reg <= '0;
                    end
                end
            end
            S_DIV_S:
            begin
                num_reg <= {num_reg[DIV_W-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_ONE;
                if (cnt_last)
                begin
                    if (|quo_next[DIV_W-1:X_W])
                    begin
                        sd_reg <= OUT_MAX;
                    end
                    else
                    begin
                        x_reg    <= quo_next[X_W-1:0];
                        root_reg <= '0;
                        bit_reg  <= {1'b1, {(ROOT_W-1){1'b0}}};
                        cnt_reg  <= CNT_W'(ROOT_STEPS);
                    end
                end
            end
            S_SQRT:
            begin
                x_reg    <= x_next;
                root_reg <= root_next;
                bit_reg  <= bit_reg >> 2;
                cnt_reg  <= cnt_reg - CNT_ONE;
                if (cnt_last)
                begin
                    sd_reg <= root_next[OUT_W-1:0];
                end
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    mean_out_reg <= mean_reg;
                    sd_out_reg   <= sd_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the latency mean and standard deviation core: a
// short table of directed samples and batch sizes, some with a set result,
// then random batches over three idle profiles, other results checked
// against an exact integer model of the batch mean and sample deviation.
// ----------------------------------------------------------------------------
module tb_top;

    import lmsd_pkg::*;

    localparam int CLOSE_CYCLES    = 200;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int PLAN_ROWS       = 24;

    typedef struct packed {
        logic [OUT_W-1:0] mean_ms;
        logic [OUT_W-1:0] std_dev_ms;
    } stats_t;

    typedef struct packed {
        bit                     set_count;
        logic [CNT_W-1:0]       count;
        logic [SAMPLE_BITS-1:0] latency;
        bit                     typed;
        logic [OUT_W-1:0]       mean_ms;
        logic [OUT_W-1:0]       std_dev_ms;
    } plan_row_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] latency_us  = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [OUT_W-1:0]       mean_ms;
    logic [OUT_W-1:0]       std_dev_ms;
    logic                   cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]       cfg_wr_data = '0;

    int sender_idle_pct   = 34;
    int receiver_idle_pct = 57;
    int mismatches        = 0;
    int cycle_count       = 0;
    int cluster_base      = 1000;
    int cluster_jitter    = 100;

    // batch model state
    logic [CNT_W-1:0] sample_count_cfg = CNT_W'(10);
    logic [SUM_W-1:0] acc_sum          = '0;
    logic [SQ_W-1:0]  acc_sq           = '0;
    logic [CNT_W-1:0] acc_seen         = '0;

    stats_t pending_stats[$];

    // batch size, latency, close, result
    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, 7'd0,   24'd1000,     1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd1000,     1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd1000,     1'b0, 31'd0,         31'd0},
        '{1'b1, 7'd2,   24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd1000,     1'b1, 31'd65536,     31'd0},
        '{1'b1, 7'd1,   24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd0,        1'b1, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd1000,     1'b1, 31'd65536,     31'd0},
        '{1'b0, 7'd0,   24'hFFFFFF,   1'b1, 31'd1099511562, 31'd0},
        '{1'b1, 7'd0,   24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd500,      1'b1, 31'd32768,     31'd0},
        '{1'b1, 7'd2,   24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd2000,     1'b1, 31'd65536,     31'd92681},
        '{1'b0, 7'd0,   24'hFFFFFF,   1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'hFFFFFF,   1'b1, 31'd1099511562, 31'd0},
        '{1'b0, 7'd0,   24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'hFFFFFF,   1'b0, 31'd0,         31'd0},
        '{1'b1, 7'd3,   24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd1234,     1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd98765,    1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd4321,     1'b0, 31'd0,         31'd0},
        '{1'b1, 7'd127, 24'd0,        1'b0, 31'd0,         31'd0},
        '{1'b0, 7'd0,   24'd7,        1'b0, 31'd0,         31'd0}
    };

    latency_mean_and_std_deviation_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .latency_us  (latency_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mean_ms     (mean_ms),
        .std_dev_ms  (std_dev_ms),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    function automatic int batch_target(input logic [CNT_W-1:0] count);
        if (count == '0)
            return 1;
        if (int'(count) > MAX_SAMPLES)
            return MAX_SAMPLES;
        return int'(count);
    endfunction

    function automatic logic [31:0] root_floor(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    task automatic accumulate_latency(input logic [SAMPLE_BITS-1:0] lat,
                                      output bit closed, output stats_t st);
        logic [63:0]  mean_full;
        logic [127:0] n_sq;
        logic [127:0] sum_sq;
        logic [127:0] spread;
        logic [127:0] denom;
        logic [127:0] var_q;
        logic [31:0]  root;
        closed = 1'b0;
        st     = '0;
        acc_sum  = acc_sum + SUM_W'(lat);
        acc_sq   = acc_sq + SQ_W'(lat) * SQ_W'(lat);
        acc_seen = acc_seen + 1'b1;
        if (int'(acc_seen) < batch_target(sample_count_cfg))
            return;
        closed    = 1'b1;
        mean_full = 64'({acc_sum, 16'd0}) / (64'(acc_seen) * 64'(US_PER_MS));
        st.mean_ms = (mean_full > 64'(OUT_MAX)) ? OUT_MAX : mean_full[OUT_W-1:0];
        if (acc_seen >= CNT_TWO)
        begin
            n_sq   = 128'(acc_seen) * 128'(acc_sq);
            sum_sq = 128'(acc_sum) * 128'(acc_sum);
            // wrapped accumulators can only go negative here; treat as zero
            if (n_sq >= sum_sq)
            begin
                spread = (n_sq - sum_sq) << 32;
                denom  = 128'(acc_seen) * 128'(acc_seen - 1'b1)
                         * 128'(US_PER_MS) * 128'(US_PER_MS);
                var_q  = spread / denom;
                if (var_q >= (128'd1 << 62))
                    st.std_dev_ms = OUT_MAX;
                else
                begin
                    root = root_floor(var_q[63:0]);
                    st.std_dev_ms = (root > 32'(OUT_MAX)) ? OUT_MAX : root[OUT_W-1:0];
                end
            end
        end
        acc_sum  = '0;
        acc_sq   = '0;
        acc_seen = '0;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] lat,
                               output bit closed, output stats_t st);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        latency_us <= lat;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        accumulate_latency(lat, closed, st);
    endtask

    task automatic write_sample_count(input logic [CNT_W-1:0] count);
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        // a sample that closes nothing may still be in flight
        repeat (CLOSE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sample_count_cfg = count;
    endtask

    function automatic logic [CNT_W-1:0] pick_sample_count();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return CNT_W'($urandom_range(1, 8));
        if (pick < 7)
            return CNT_W'($urandom_range(1, MAX_SAMPLES));
        case ($urandom_range(5))
            0:       return CNT_W'(0);
            1:       return CNT_ONE;
            2:       return CNT_TWO;
            3:       return CNT_MAX;
            4:       return CNT_MAX + CNT_ONE;
            default: return {CNT_W{1'b1}};
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_latency();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {SAMPLE_BITS{1'b1}};
            2, 3:    return SAMPLE_BITS'($urandom());
            4, 5:    return SAMPLE_BITS'($urandom_range(0, 5000));
            9:       return SAMPLE_BITS'(1) << $urandom_range(SAMPLE_BITS - 1);
            // realistic latencies: tight spread around a common value
            default: return SAMPLE_BITS'(cluster_base + $urandom_range(0, cluster_jitter));
        endcase
    endfunction

    always @(posedge clk)
        out_stall <= (receiver_idle_pct > 0) && ($urandom_range(99) < receiver_idle_pct);

    always @(posedge clk)
    begin
        stats_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $error("unexpected result: mean_ms %0d std_dev_ms %0d", mean_ms, std_dev_ms);
                mismatches++;
            end
            else
            begin
                want = pending_stats.pop_front();
                if (mean_ms !== want.mean_ms)
                begin
                    $error("mean_ms: expected %0d, got %0d", want.mean_ms, mean_ms);
                    mismatches++;
                end
                if (std_dev_ms !== want.std_dev_ms)
                begin
                    $error("std_dev_ms: expected %0d, got %0d", want.std_dev_ms, std_dev_ms);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("latency_mean_and_std_deviation_core test failed");
            $finish;
        end
    end

    initial
    begin
        bit               closed;
        stats_t           st;
        logic [CNT_W-1:0] count;
        int               block_len;
        int               phase_items;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].set_count)
                write_sample_count(plan[i].count);
            else
            begin
                send_sample(plan[i].latency, closed, st);
                if (plan[i].typed)
                begin
                    closed        = 1'b1;
                    st.mean_ms    = plan[i].mean_ms;
                    st.std_dev_ms = plan[i].std_dev_ms;
                end
                if (closed)
                    pending_stats.push_back(st);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 34;
                    receiver_idle_pct = 57;
                end
                1:
                begin
                    sender_idle_pct   = 57;
                    receiver_idle_pct = 34;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                count = pick_sample_count();
                write_sample_count(count);
                block_len = batch_target(count) * $urandom_range(1, 2);
                // leave a partial batch behind for the next size change
                if ($urandom_range(3) == 0)
                    block_len += $urandom_range(1, batch_target(count));
                cluster_base   = $urandom_range(100, 2000000);
                cluster_jitter = $urandom_range(0, 3000);
                for (int k = 0; k < block_len; k++)
                begin
                    send_sample(pick_latency(), closed, st);
                    if (closed)
                        pending_stats.push_back(st);
                end
                phase_items += block_len;
            end
        end

        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (CLOSE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("latency_mean_and_std_deviation_core test passed");
        else
            $display("latency_mean_and_std_deviation_core test failed");
        $finish;
    end

endmodule
